>>> hw/rtl/dpsa_pkg.sv
// Shared types and constants for the DMA pool slot allocator.
// Used by the controller, the datapath and the top level; no dependencies.
package dpsa_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int OFF_W      = 13;   // byte offset inside a page, 0..4096
    localparam int ADDR_W     = 48;
    localparam int FRAME_W    = 36;
    localparam int UNIT_W     = 13;
    localparam int ALIGN_W    = 13;
    localparam int BOUND_W    = 21;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 21;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_UNIT_SIZE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALIGNMENT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BOUNDARY  = 2'd2;

    // Request kinds carried on s_tuser
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_ROOM     = 2'd1,
        ST_FREE_REJECT = 2'd2,
        ST_CFG_INVALID = 2'd3
    } status_t;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_item;
        logic    pg_first;
        logic    rd_page;
        logic    pg_next;
        logic    adopt;
        logic    scan_init;
        logic    scan_step;
        logic    commit_alloc;
        logic    commit_free;
        logic    set_status;
        status_t status;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic cfg_ok;
        logic op_free;
        logic pages_left;
        logic pool_full;
        logic slot_in_range;
        logic slot_fits;
        logic frame_hit;
        logic off_reached;
        logic off_match;
        logic bit_set;
        logic taken;
    } dp_sts_t;

endpackage

>>> hw/rtl/dpsa_ctrl.sv
// Sequencing state machine of the slot allocator.
// Depends on dpsa_pkg for the command and status structs.
module dpsa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic             out_free,
    output logic             emit,
    input  dpsa_pkg::dp_sts_t sts,
    output dpsa_pkg::dp_cmd_t cmd
);
    import dpsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_A_PAGE,
        S_A_SCAN,
        S_F_PAGE,
        S_F_CMP,
        S_F_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign s_tready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        cmd        = '0;
        cmd.status = ST_OK;
        emit       = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.pg_first = 1'b1;
                if (!sts.cfg_ok) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_CFG_INVALID;
                    state_next     = S_DONE;
                end else if (sts.op_free) begin
                    state_next = S_F_PAGE;
                end else begin
                    state_next = S_A_PAGE;
                end
            end
            S_A_PAGE: begin
                if (sts.pages_left) begin
                    cmd.rd_page   = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_A_SCAN;
                end else if (!sts.pool_full) begin
                    cmd.adopt     = 1'b1;
                    cmd.scan_init = 1'b1;
                    state_next    = S_A_SCAN;
                end else begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_NO_ROOM;
                    state_next     = S_DONE;
                end
            end
            S_A_SCAN: begin
                if (!sts.slot_in_range) begin
                    // page exhausted: a freshly adopted page ends the search
                    if (sts.taken) begin
                        cmd.set_status = 1'b1;
                        cmd.status     = ST_NO_ROOM;
                        state_next     = S_DONE;
                    end else begin
                        cmd.pg_next = 1'b1;
                        state_next  = S_A_PAGE;
                    end
                end else if (sts.slot_fits) begin
                    cmd.commit_alloc = 1'b1;
                    state_next       = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_F_PAGE: begin
                if (sts.pages_left) begin
                    cmd.rd_page = 1'b1;
                    state_next  = S_F_CMP;
                end else begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FREE_REJECT;
                    state_next     = S_DONE;
                end
            end
            S_F_CMP: begin
                if (sts.frame_hit) begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_F_DIV;
                end else begin
                    cmd.pg_next = 1'b1;
                    state_next  = S_F_PAGE;
                end
            end
            S_F_DIV: begin
                // walk slot offsets until the freed offset is met or passed
                if (sts.off_match && sts.slot_in_range && sts.bit_set) begin
                    cmd.commit_free = 1'b1;
                    state_next      = S_DONE;
                end else if (sts.off_reached || !sts.slot_in_range) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ST_FREE_REJECT;
                    state_next     = S_DONE;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hw/rtl/dpsa_datapath.sv
// Datapath of the slot allocator: geometry check, page frame and bitmap stores,
// slot scan counters and result registers. Depends on dpsa_pkg.
module dpsa_datapath #(
    parameter int MAX_PAGES = 8,
    parameter int MAX_SLOTS = 512
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           clear_pool,
    input  logic [dpsa_pkg::UNIT_W-1:0]    unit_size,
    input  logic [dpsa_pkg::ALIGN_W-1:0]   alignment,
    input  logic [dpsa_pkg::BOUND_W-1:0]   boundary,
    input  logic                           in_op,
    input  logic [dpsa_pkg::ADDR_W-1:0]    in_free_address,
    input  logic [dpsa_pkg::FRAME_W-1:0]   in_new_page_frame,
    input  dpsa_pkg::dp_cmd_t              cmd,
    output dpsa_pkg::dp_sts_t              sts,
    output dpsa_pkg::status_t              res_status,
    output logic [dpsa_pkg::ADDR_W-1:0]    res_slot_address,
    output logic                           res_page_taken
);
    import dpsa_pkg::*;

    localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CW = $clog2(MAX_PAGES + 1);
    localparam int SW = $clog2(MAX_SLOTS);
    localparam int IW = $clog2(MAX_SLOTS + 1);

    // Captured transaction
    logic                op_reg;
    logic [ADDR_W-1:0]   faddr_reg;
    logic [FRAME_W-1:0]  nframe_reg;

    // Scan state
    logic [CW-1:0]       p_reg;
    logic [CW-1:0]       cnt_reg;
    logic [IW-1:0]       i_reg;
    logic [OFF_W-1:0]    off_reg;
    logic                zero_row_reg;

    // Stores and their read registers
    logic [FRAME_W-1:0]   frame_mem [MAX_PAGES];
    logic [MAX_SLOTS-1:0] bm_mem    [MAX_PAGES];
    logic [FRAME_W-1:0]   cur_frame_reg;
    logic [MAX_SLOTS-1:0] row_q_reg;

    // Results
    status_t             status_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                taken_reg;

    // Geometry
    logic [ALIGN_W-1:0]  a_eff;
    logic [OFF_W:0]      a_m1;
    logic [OFF_W:0]      slot_w;
    logic [OFF_W-1:0]    slot;
    logic [BOUND_W-1:0]  b_m1;
    logic                a_pow2;
    logic                b_ok;
    logic                cfg_ok;

    // Per-slot checks
    logic [OFF_W-1:0]     off_end;
    logic                 crosses;
    logic                 in_range;
    logic [MAX_SLOTS-1:0] row;
    logic                 bit_cur;
    logic [MAX_SLOTS-1:0] row_wr;
    logic [PW-1:0]        bm_waddr;
    logic                 bm_we;

    // Round the unit up to the alignment and validate the configuration
    always_comb begin
        a_eff  = (alignment == '0) ? ALIGN_W'(1) : alignment;
        a_m1   = {1'b0, a_eff} - (OFF_W + 1)'(1);
        a_pow2 = ((a_eff & (a_eff - ALIGN_W'(1))) == '0);
        slot_w = ({1'b0, unit_size} + a_m1) & ~a_m1;
        slot   = slot_w[OFF_W-1:0];
        b_m1   = boundary - BOUND_W'(1);
        b_ok   = (boundary == '0) ||
                 (((boundary & b_m1) == '0) &&
                  ({{(BOUND_W-OFF_W-1){1'b0}}, slot_w} <= boundary));
        cfg_ok = (unit_size != '0) && a_pow2 &&
                 ({1'b0, a_eff} <= (OFF_W + 1)'(PAGE_BYTES)) &&
                 (slot_w <= (OFF_W + 1)'(PAGE_BYTES)) && b_ok;
    end

    // Boundary crossing and range of the current slot
    always_comb begin
        off_end  = off_reg + slot - OFF_W'(1);
        crosses  = (boundary != '0) && (((off_reg ^ off_end) & ~b_m1[OFF_W-1:0]) != '0);
        in_range = (i_reg < IW'(MAX_SLOTS)) &&
                   (({1'b0, off_reg} + {1'b0, slot}) <= (OFF_W + 1)'(PAGE_BYTES));
        row      = zero_row_reg ? '0 : row_q_reg;
        bit_cur  = row[i_reg[SW-1:0]];
        row_wr   = row;
        row_wr[i_reg[SW-1:0]] = cmd.commit_alloc;
        bm_we    = cmd.adopt || cmd.commit_alloc || cmd.commit_free;
        bm_waddr = cmd.adopt ? cnt_reg[PW-1:0] : p_reg[PW-1:0];
    end

    // Frame store: adopt writes, page read loads the current frame
    always_ff @(posedge aclk) begin
        if (cmd.adopt) begin
            frame_mem[cnt_reg[PW-1:0]] <= nframe_reg;
            cur_frame_reg              <= nframe_reg;
        end else if (cmd.rd_page) begin
            cur_frame_reg <= frame_mem[p_reg[PW-1:0]];
        end
    end

    // Bitmap store: adopt writes an empty row, commits write the updated row
    always_ff @(posedge aclk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= cmd.adopt ? '0 : row_wr;
        end
        if (cmd.rd_page) begin
            row_q_reg <= bm_mem[p_reg[PW-1:0]];
        end
    end

    // Transaction capture and results
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg     <= in_op;
            faddr_reg  <= in_free_address;
            nframe_reg <= in_new_page_frame;
            status_reg <= ST_OK;
            addr_reg   <= '0;
            taken_reg  <= 1'b0;
        end else begin
            if (cmd.set_status) begin
                status_reg <= cmd.status;
            end
            if (cmd.adopt) begin
                taken_reg <= 1'b1;
            end
            if (cmd.commit_alloc) begin
                addr_reg <= {cur_frame_reg, off_reg[OFF_W-2:0]};
            end
        end
    end

    // Page walk and slot counters
    always_ff @(posedge aclk) begin
        if (cmd.pg_first) begin
            p_reg <= '0;
        end else if (cmd.pg_next) begin
            p_reg <= p_reg + CW'(1);
        end else if (cmd.adopt) begin
            p_reg <= cnt_reg;
        end
        if (cmd.rd_page) begin
            zero_row_reg <= 1'b0;
        end else if (cmd.adopt) begin
            zero_row_reg <= 1'b1;
        end
        if (cmd.scan_init) begin
            i_reg   <= '0;
            off_reg <= '0;
        end else if (cmd.scan_step) begin
            i_reg   <= i_reg + IW'(1);
            off_reg <= off_reg + slot;
        end
    end

    // Page count: emptied by reset and by any register write
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_pool) begin
            cnt_reg <= '0;
        end else if (cmd.adopt) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_comb begin
        sts.cfg_ok        = cfg_ok;
        sts.op_free       = (op_reg == OP_FREE);
        sts.pages_left    = (p_reg < cnt_reg);
        sts.pool_full     = (cnt_reg == CW'(MAX_PAGES));
        sts.slot_in_range = in_range;
        sts.slot_fits     = !bit_cur && !crosses;
        sts.frame_hit     = (faddr_reg[ADDR_W-1:12] == cur_frame_reg);
        sts.off_reached   = (off_reg >= {1'b0, faddr_reg[11:0]});
        sts.off_match     = (off_reg == {1'b0, faddr_reg[11:0]});
        sts.bit_set       = bit_cur;
        sts.taken         = taken_reg;
    end

    assign res_status       = status_reg;
    assign res_slot_address = addr_reg;
    assign res_page_taken   = taken_reg;

endmodule

>>> hw/rtl/dma_pool_slot_allocator_unit.sv
// Channel   Dir  Payload
// s_*       in   tuser: op; tdata: free_address, new_page_frame
// m_*       out  tuser: status; tdata: slot_address, page_taken
// cfg_*     in   unit_size (0), alignment (1), boundary (2)
//
// One transaction at a time. An allocate steps through the pages (each page read,
// an adoption or the final no-room decision), moving on past each page found full,
// and examines slots with the scan counter; a free compares the frame of each page
// and then steps slot offsets up to the freed address. Worst case is set by that
// slot counter. Reset and any register write empty the pool; no clearing pass.
// A finished result waits in the output register while the next request is taken.
// Top level of the slot allocator; depends on dpsa_pkg, dpsa_ctrl, dpsa_datapath.
module dma_pool_slot_allocator_unit #(
    parameter int MAX_PAGES = 8,
    parameter int MAX_SLOTS = 512
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [87:0]                       s_tdata,   // free_address[47:0], new_page_frame[83:48], pad
    input  logic                              s_tuser,   // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [55:0]                       m_tdata,   // slot_address[47:0], page_taken[48], pad
    output logic [1:0]                        m_tuser,   // status
    input  logic                              cfg_we,
    input  logic [dpsa_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dpsa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import dpsa_pkg::*;

    logic [UNIT_W-1:0]  unit_size_reg;
    logic [ALIGN_W-1:0] alignment_reg;
    logic [BOUND_W-1:0] boundary_reg;
    logic               clear_pool;

    logic               m_tvalid_reg;
    logic [55:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    dp_cmd_t            cmd;
    dp_sts_t            sts;
    logic               emit;
    logic               out_free;
    status_t            res_status;
    logic [ADDR_W-1:0]  res_slot_address;
    logic               res_page_taken;

    // Configuration registers; any known register write empties the pool
    assign clear_pool = cfg_we && (cfg_addr == REG_UNIT_SIZE ||
                                   cfg_addr == REG_ALIGNMENT ||
                                   cfg_addr == REG_BOUNDARY);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_size_reg <= UNIT_W'(64);
            alignment_reg <= ALIGN_W'(64);
            boundary_reg  <= BOUND_W'(4096);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_UNIT_SIZE: unit_size_reg <= cfg_wdata[UNIT_W-1:0];
                REG_ALIGNMENT: alignment_reg <= cfg_wdata[ALIGN_W-1:0];
                REG_BOUNDARY:  boundary_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    dpsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .out_free (out_free),
        .emit     (emit),
        .sts      (sts),
        .cmd      (cmd)
    );

    dpsa_datapath #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .clear_pool        (clear_pool),
        .unit_size         (unit_size_reg),
        .alignment         (alignment_reg),
        .boundary          (boundary_reg),
        .in_op             (s_tuser),
        .in_free_address   (s_tdata[47:0]),
        .in_new_page_frame (s_tdata[83:48]),
        .cmd               (cmd),
        .sts               (sts),
        .res_status        (res_status),
        .res_slot_address  (res_slot_address),
        .res_page_taken    (res_page_taken)
    );

    // Output register: load on emit, drop valid when taken
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {7'd0, res_page_taken, res_slot_address};
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Only a successful allocate carries an address
    a_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[47:0] == 48'd0))
        else $error("nonzero slot address on a failed transaction");

    // An adopted frame only comes with ok or no-room
    a_taken_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[48] |-> (m_tuser == ST_OK || m_tuser == ST_NO_ROOM))
        else $error("page taken with wrong status");

    // One transaction at a time: busy right after accepting
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while busy");

endmodule
